/* rtl/jvcs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jvcs_pkg
// Shared widths, codes, reset values and helpers for the joystick velocity
// command scaler.
// ----------------------------------------------------------------------------
package jvcs_pkg;

	localparam int unsigned BTN_W   = 10;
	localparam int unsigned AXIS_W  = 16;
	localparam int unsigned SCALE_W = 15;
	localparam int unsigned VEL_W   = 16;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned PROD_W  = AXIS_W + SCALE_W + 1;

	// item kinds
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_LIN_MIN  = 3'd0;
	localparam logic [2:0] REG_LIN_MAX  = 3'd1;
	localparam logic [2:0] REG_LIN_STEP = 3'd2;
	localparam logic [2:0] REG_ANG_MIN  = 3'd3;
	localparam logic [2:0] REG_ANG_MAX  = 3'd4;
	localparam logic [2:0] REG_ANG_STEP = 3'd5;

	// button bits
	localparam int unsigned BTN_ANG_DOWN = 0;
	localparam int unsigned BTN_LIN_DOWN = 1;
	localparam int unsigned BTN_ANG_UP   = 2;
	localparam int unsigned BTN_LIN_UP   = 3;
	localparam int unsigned BTN_DISABLE  = 4;
	localparam int unsigned BTN_ENABLE   = 5;
	localparam int unsigned BTN_ALL_MIN  = 8;
	localparam int unsigned BTN_ALL_MAX  = 9;

	// register reset values, Q3.12
	localparam logic [SCALE_W-1:0] RST_LIN_MIN  = 15'd819;
	localparam logic [SCALE_W-1:0] RST_LIN_MAX  = 15'd8192;
	localparam logic [SCALE_W-1:0] RST_LIN_STEP = 15'd819;
	localparam logic [SCALE_W-1:0] RST_ANG_MIN  = 15'd2048;
	localparam logic [SCALE_W-1:0] RST_ANG_MAX  = 15'd16384;
	localparam logic [SCALE_W-1:0] RST_ANG_STEP = 15'd819;

	typedef struct packed {
		logic [SCALE_W-1:0] lin_min;
		logic [SCALE_W-1:0] lin_max;
		logic [SCALE_W-1:0] lin_step;
		logic [SCALE_W-1:0] ang_min;
		logic [SCALE_W-1:0] ang_max;
		logic [SCALE_W-1:0] ang_step;
	} jvcs_cfg_t;

	// scale state and the axes captured by the last sample
	typedef struct packed {
		logic [SCALE_W-1:0]        lin_scale;
		logic [SCALE_W-1:0]        ang_scale;
		logic                      enabled;
		logic signed [AXIS_W-1:0]  lin_axis;
		logic signed [AXIS_W-1:0]  ang_axis;
	} jvcs_state_t;

	// clamp the scale down: max(s - step, lo), signed difference
	function automatic logic [SCALE_W-1:0] step_down(
		input logic [SCALE_W-1:0] s,
		input logic [SCALE_W-1:0] step,
		input logic [SCALE_W-1:0] lo
	);
		logic signed [SCALE_W+1:0] v;
		begin
			v = $signed({2'b00, s}) - $signed({2'b00, step});
			step_down = (v < $signed({2'b00, lo})) ? lo : v[SCALE_W-1:0];
		end
	endfunction

	// clamp the scale up: min(s + step, hi)
	function automatic logic [SCALE_W-1:0] step_up(
		input logic [SCALE_W-1:0] s,
		input logic [SCALE_W-1:0] step,
		input logic [SCALE_W-1:0] hi
	);
		logic [SCALE_W:0] v;
		begin
			v = {1'b0, s} + {1'b0, step};
			step_up = (v > {1'b0, hi}) ? hi : v[SCALE_W-1:0];
		end
	endfunction

	// Q1.15 x Q3.12 product floored to Q3.12 and saturated
	function automatic logic signed [VEL_W-1:0] scale_sat(
		input logic signed [PROD_W-1:0] p
	);
		logic signed [PROD_W-16:0] q;
		begin
			q = p[PROD_W-1:15];
			if (q > $signed((PROD_W-15)'(32767)))
				scale_sat = 16'sh7FFF;
			else if (q < $signed(-(PROD_W-15)'(32768)))
				scale_sat = 16'sh8000;
			else
				scale_sat = q[VEL_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

/* rtl/jvcs_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jvcs_in_if / jvcs_out_if
// Valid/ready channels for joystick words in and velocity words out.
// ----------------------------------------------------------------------------
interface jvcs_in_if
	import jvcs_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic                     op;
	logic [BTN_W-1:0]         buttons;
	logic signed [AXIS_W-1:0] stick_x;
	logic signed [AXIS_W-1:0] stick_y;
	logic signed [AXIS_W-1:0] pad_x;
	logic signed [AXIS_W-1:0] pad_y;

	modport source (output valid, op, buttons, stick_x, stick_y, pad_x, pad_y,
		input ready);
	modport sink (input valid, op, buttons, stick_x, stick_y, pad_x, pad_y,
		output ready);
endinterface

interface jvcs_out_if
	import jvcs_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic signed [VEL_W-1:0] linear_velocity;
	logic signed [VEL_W-1:0] angular_velocity;
	logic                    sending;

	modport source (output valid, linear_velocity, angular_velocity, sending,
		input ready);
	modport sink (input valid, linear_velocity, angular_velocity, sending,
		output ready);
endinterface
`default_nettype wire

/* rtl/jvcs_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jvcs_ctrl
// Button edge handling, scale stepping and the axes held for the next tick.
// ----------------------------------------------------------------------------
module jvcs_ctrl
	import jvcs_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     upd,
	input  wire logic                     clr,
	input  wire logic [BTN_W-1:0]         buttons,
	input  wire logic signed [AXIS_W-1:0] stick_x,
	input  wire logic signed [AXIS_W-1:0] stick_y,
	input  wire logic signed [AXIS_W-1:0] pad_x,
	input  wire logic signed [AXIS_W-1:0] pad_y,
	input  wire jvcs_cfg_t                cfg,
	output jvcs_state_t                   st
);

	logic [BTN_W-1:0] prev_btn_q;
	logic             have_prev_q;
	jvcs_state_t      st_q;
	jvcs_state_t      st_d;
	logic [BTN_W-1:0] rise;

	assign rise = have_prev_q ? (buttons & ~prev_btn_q) : '0;

	// first rising edge in priority order picks the action
	always_comb begin
		st_d = st_q;
		if (rise[BTN_ANG_DOWN]) begin
			st_d.ang_scale = step_down(st_q.ang_scale, cfg.ang_step, cfg.ang_min);
		end else if (rise[BTN_LIN_DOWN]) begin
			st_d.lin_scale = step_down(st_q.lin_scale, cfg.lin_step, cfg.lin_min);
		end else if (rise[BTN_ANG_UP]) begin
			st_d.ang_scale = step_up(st_q.ang_scale, cfg.ang_step, cfg.ang_max);
		end else if (rise[BTN_LIN_UP]) begin
			st_d.lin_scale = step_up(st_q.lin_scale, cfg.lin_step, cfg.lin_max);
		end else if (rise[BTN_DISABLE]) begin
			st_d.enabled = 1'b0;
		end else if (rise[BTN_ENABLE]) begin
			st_d.enabled = 1'b1;
		end else if (rise[BTN_ALL_MIN]) begin
			st_d.lin_scale = cfg.lin_min;
			st_d.ang_scale = cfg.ang_min;
		end else if (rise[BTN_ALL_MAX]) begin
			st_d.lin_scale = cfg.lin_max;
			st_d.ang_scale = cfg.ang_max;
		end
		// pad axis wins when nonzero
		st_d.lin_axis = (pad_y != '0) ? pad_y : stick_y;
		st_d.ang_axis = (pad_x != '0) ? pad_x : stick_x;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_btn_q       <= '0;
			have_prev_q      <= 1'b0;
			st_q.lin_scale   <= RST_LIN_MIN;
			st_q.ang_scale   <= RST_ANG_MIN;
			st_q.enabled     <= 1'b1;
			st_q.lin_axis    <= '0;
			st_q.ang_axis    <= '0;
		end else if (upd) begin
			prev_btn_q  <= buttons;
			have_prev_q <= 1'b1;
			st_q        <= st_d;
		end else if (clr) begin
			st_q.lin_axis <= '0;
			st_q.ang_axis <= '0;
		end
	end

	assign st = st_q;

	// before the first sample nothing has moved from reset
	a_untouched: assert property (@(posedge clk) disable iff (!arst_n)
		!have_prev_q |-> (st_q.lin_scale == RST_LIN_MIN &&
			st_q.ang_scale == RST_ANG_MIN && st_q.enabled &&
			st_q.lin_axis == '0 && st_q.ang_axis == '0))
		else $error("state left reset before first sample");

	a_have_prev: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> have_prev_q)
		else $error("previous buttons not marked after sample");

	a_disable: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && rise[BTN_DISABLE] && rise[BTN_LIN_UP:BTN_ANG_DOWN] == '0)
			|=> !st_q.enabled)
		else $error("disable press did not stop sending");

endmodule
`default_nettype wire

/* rtl/joystick_velocity_command_scaler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_velocity_command_scaler
// Turns joystick words into scaled speed and turn commands sent on ticks.
// A tick word passes the input stage register, then the output register.
// Throughput: one word per cycle; a tick waits in the input stage only while
// the output register is full and not being taken.
// Reset: scales 0.2 / 0.5, sending on, held speeds zero, registers at defaults.
// ----------------------------------------------------------------------------
module joystick_velocity_command_scaler
	import jvcs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	jvcs_in_if.sink                cmd_in,
	jvcs_out_if.source             cmd_out,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	jvcs_cfg_t                cfg_q;
	logic [2:0]               reg_idx;
	logic                     cfg_wr;

	logic                     valid_s1;
	logic                     op_s1;
	logic [BTN_W-1:0]         buttons_s1;
	logic signed [AXIS_W-1:0] stick_x_s1;
	logic signed [AXIS_W-1:0] stick_y_s1;
	logic signed [AXIS_W-1:0] pad_x_s1;
	logic signed [AXIS_W-1:0] pad_y_s1;
	logic                     go_s1;
	logic                     in_acc;
	logic                     tick_go;

	jvcs_state_t              st;
	logic signed [PROD_W-1:0] lin_prod;
	logic signed [PROD_W-1:0] ang_prod;

	logic                     out_valid_q;
	logic signed [VEL_W-1:0]  lin_q;
	logic signed [VEL_W-1:0]  ang_q;
	logic                     sending_q;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lin_min  <= RST_LIN_MIN;
			cfg_q.lin_max  <= RST_LIN_MAX;
			cfg_q.lin_step <= RST_LIN_STEP;
			cfg_q.ang_min  <= RST_ANG_MIN;
			cfg_q.ang_max  <= RST_ANG_MAX;
			cfg_q.ang_step <= RST_ANG_STEP;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_LIN_MIN:  cfg_q.lin_min  <= pwdata[SCALE_W-1:0];
				REG_LIN_MAX:  cfg_q.lin_max  <= pwdata[SCALE_W-1:0];
				REG_LIN_STEP: cfg_q.lin_step <= pwdata[SCALE_W-1:0];
				REG_ANG_MIN:  cfg_q.ang_min  <= pwdata[SCALE_W-1:0];
				REG_ANG_MAX:  cfg_q.ang_max  <= pwdata[SCALE_W-1:0];
				REG_ANG_STEP: cfg_q.ang_step <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_LIN_MIN:  prdata = DATA_W'(cfg_q.lin_min);
			REG_LIN_MAX:  prdata = DATA_W'(cfg_q.lin_max);
			REG_LIN_STEP: prdata = DATA_W'(cfg_q.lin_step);
			REG_ANG_MIN:  prdata = DATA_W'(cfg_q.ang_min);
			REG_ANG_MAX:  prdata = DATA_W'(cfg_q.ang_max);
			REG_ANG_STEP: prdata = DATA_W'(cfg_q.ang_step);
			default:      prdata = '0;
		endcase
	end

	// input stage; only a tick can stall it
	assign go_s1 = valid_s1 && (op_s1 == OP_SAMPLE || !out_valid_q || cmd_out.ready);
	assign cmd_in.ready = !valid_s1 || go_s1;
	assign in_acc  = cmd_in.valid && cmd_in.ready;
	assign tick_go = go_s1 && op_s1 == OP_TICK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1      <= cmd_in.op;
			buttons_s1 <= cmd_in.buttons;
			stick_x_s1 <= cmd_in.stick_x;
			stick_y_s1 <= cmd_in.stick_y;
			pad_x_s1   <= cmd_in.pad_x;
			pad_y_s1   <= cmd_in.pad_y;
		end
	end

	// scale state; a tick while disabled clears the held axes
	jvcs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (go_s1 && op_s1 == OP_SAMPLE),
		.clr     (tick_go && !st.enabled),
		.buttons (buttons_s1),
		.stick_x (stick_x_s1),
		.stick_y (stick_y_s1),
		.pad_x   (pad_x_s1),
		.pad_y   (pad_y_s1),
		.cfg     (cfg_q),
		.st      (st)
	);

	// speeds: held axis times current scale (scale only moves with a new axis)
	assign lin_prod = PROD_W'(st.lin_axis) * $signed({1'b0, st.lin_scale});
	assign ang_prod = PROD_W'(st.ang_axis) * $signed({1'b0, st.ang_scale});

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_go) begin
			out_valid_q <= 1'b1;
		end else if (cmd_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			lin_q     <= st.enabled ? scale_sat(lin_prod) : '0;
			ang_q     <= st.enabled ? scale_sat(ang_prod) : '0;
			sending_q <= st.enabled;
		end
	end

	assign cmd_out.valid            = out_valid_q;
	assign cmd_out.linear_velocity  = lin_q;
	assign cmd_out.angular_velocity = ang_q;
	assign cmd_out.sending          = sending_q;

	a_tick_out: assert property (@(posedge clk) disable iff (!arst_n)
		tick_go |=> out_valid_q)
		else $error("tick left input stage without a word");

	a_zero_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !sending_q) |-> (lin_q == '0 && ang_q == '0))
		else $error("nonzero speed while sending is off");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_in.ready |-> (valid_s1 && op_s1 == OP_TICK && out_valid_q))
		else $error("input stalled without a blocked tick");

endmodule
`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Sends joystick sample and tick words to the scaler at random rates. It
// writes the scale registers over APB between phases, and it checks every
// velocity word, field by field, against a software copy of the scale,
// enable and hold logic.
// ----------------------------------------------------------------------------
module testbench
	import jvcs_pkg::*;
;

	localparam int unsigned HALF_PERIOD    = 6;
	localparam int unsigned RESET_CYCLES   = 2;
	localparam int unsigned DRAIN_CYCLES   = 4;
	localparam int unsigned HOLD_CYCLES    = 200;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned PHASE_WORDS    = 280;
	localparam int unsigned NUM_PHASES     = 6;
	localparam int unsigned IDLE_PCT       = 29;
	localparam int unsigned TICK_PCT       = 35;
	localparam int unsigned SCALE_TOP      = (1 << SCALE_W) - 1;

	// addresses past the last register; writes there must change nothing
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic                     op;
		logic [BTN_W-1:0]         buttons;
		logic signed [AXIS_W-1:0] stick_x;
		logic signed [AXIS_W-1:0] stick_y;
		logic signed [AXIS_W-1:0] pad_x;
		logic signed [AXIS_W-1:0] pad_y;
	} joy_word_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] lin;
		logic signed [VEL_W-1:0] ang;
		logic                    sending;
	} vel_word_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	jvcs_in_if  joy_ch();
	jvcs_out_if vel_ch();

	joystick_velocity_command_scaler u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_in  (joy_ch),
		.cmd_out (vel_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predicted block state and register copy
	jvcs_cfg_t               cfg_regs;
	logic [SCALE_W-1:0]      lin_scale_m;
	logic [SCALE_W-1:0]      ang_scale_m;
	logic                    sending_m;
	logic signed [VEL_W-1:0] held_lin_m;
	logic signed [VEL_W-1:0] held_ang_m;
	logic [BTN_W-1:0]        last_buttons_m;
	logic                    seen_sample_m;

	joy_word_t   joy_pending_q[$];
	vel_word_t   vel_expect_q[$];
	joy_word_t   drive_word;
	vel_word_t   want_word;
	int unsigned queued_cnt = 0;
	int unsigned accepted_cnt = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned quiet_cycles = 0;
	int unsigned src_idle_pct = IDLE_PCT;
	int unsigned sink_idle_pct = IDLE_PCT;
	int unsigned hold_left = 0;
	logic        hold_go = 1'b0;
	logic        hold_used = 1'b0;
	logic [BTN_W-1:0] gen_buttons = '0;

	always #HALF_PERIOD clk = ~clk;

	// scale step with floor; difference taken signed
	function automatic logic [SCALE_W-1:0] scale_down(input int cur, input int dec,
			input int floor_v);
		int v;
		v = cur - dec;
		return (v < floor_v) ? floor_v[SCALE_W-1:0] : v[SCALE_W-1:0];
	endfunction

	// scale step with ceiling; sum may pass 15 bits before the clamp
	function automatic logic [SCALE_W-1:0] scale_up(input int cur, input int inc,
			input int ceil_v);
		int v;
		v = cur + inc;
		return (v > ceil_v) ? ceil_v[SCALE_W-1:0] : v[SCALE_W-1:0];
	endfunction

	// Q1.15 axis times Q3.12 scale, floored to Q3.12, saturated
	function automatic logic signed [VEL_W-1:0] axis_speed(
			input logic signed [AXIS_W-1:0] axis, input logic [SCALE_W-1:0] scale);
		longint prod;
		longint q;
		prod = longint'(axis) * longint'(scale);
		q = prod >>> 15;
		if (q > 32767)
			q = 32767;
		else if (q < -32768)
			q = -32768;
		return q[VEL_W-1:0];
	endfunction

	// advance the predicted state by one accepted word
	function automatic void advance_scaler(input joy_word_t w);
		logic [BTN_W-1:0] rise;
		vel_word_t res;
		if (w.op == OP_TICK) begin
			if (!sending_m) begin
				held_lin_m = '0;
				held_ang_m = '0;
			end
			res.lin = held_lin_m;
			res.ang = held_ang_m;
			res.sending = sending_m;
			vel_expect_q.push_back(res);
			return;
		end
		rise = w.buttons & ~last_buttons_m;
		if (seen_sample_m) begin
			if (rise[BTN_ANG_DOWN])
				ang_scale_m = scale_down(ang_scale_m, cfg_regs.ang_step, cfg_regs.ang_min);
			else if (rise[BTN_LIN_DOWN])
				lin_scale_m = scale_down(lin_scale_m, cfg_regs.lin_step, cfg_regs.lin_min);
			else if (rise[BTN_ANG_UP])
				ang_scale_m = scale_up(ang_scale_m, cfg_regs.ang_step, cfg_regs.ang_max);
			else if (rise[BTN_LIN_UP])
				lin_scale_m = scale_up(lin_scale_m, cfg_regs.lin_step, cfg_regs.lin_max);
			else if (rise[BTN_DISABLE])
				sending_m = 1'b0;
			else if (rise[BTN_ENABLE])
				sending_m = 1'b1;
			else if (rise[BTN_ALL_MIN]) begin
				lin_scale_m = cfg_regs.lin_min;
				ang_scale_m = cfg_regs.ang_min;
			end else if (rise[BTN_ALL_MAX]) begin
				lin_scale_m = cfg_regs.lin_max;
				ang_scale_m = cfg_regs.ang_max;
			end
		end
		// a nonzero pad axis overrides the stick
		held_lin_m = axis_speed((w.pad_y != 0) ? w.pad_y : w.stick_y, lin_scale_m);
		held_ang_m = axis_speed((w.pad_x != 0) ? w.pad_x : w.stick_x, ang_scale_m);
		last_buttons_m = w.buttons;
		seen_sample_m = 1'b1;
	endfunction

	function automatic logic [BTN_W-1:0] btn(input int unsigned idx);
		return BTN_W'(1) << idx;
	endfunction

	function automatic joy_word_t sample_word(input logic [BTN_W-1:0] b,
			input logic signed [AXIS_W-1:0] sx, input logic signed [AXIS_W-1:0] sy,
			input logic signed [AXIS_W-1:0] px, input logic signed [AXIS_W-1:0] py);
		joy_word_t w;
		w.op = OP_SAMPLE;
		w.buttons = b;
		w.stick_x = sx;
		w.stick_y = sy;
		w.pad_x = px;
		w.pad_y = py;
		return w;
	endfunction

	// ticks carry junk in the other fields; the block must ignore it
	function automatic joy_word_t tick_word();
		logic [95:0] junk;
		joy_word_t w;
		junk = {$urandom, $urandom, $urandom};
		w = junk[$bits(joy_word_t)-1:0];
		w.op = OP_TICK;
		return w;
	endfunction

	function automatic logic signed [AXIS_W-1:0] pick_axis();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return -16'sd1;
			4: return 16'sd1;
			default: return AXIS_W'($urandom);
		endcase
	endfunction

	// mostly single press/release changes, now and then a random set
	function automatic joy_word_t random_word();
		if ($urandom_range(0, 99) < TICK_PCT)
			return tick_word();
		case ($urandom_range(0, 9))
			0: gen_buttons = BTN_W'($urandom);
			1: gen_buttons = '0;
			default: gen_buttons = gen_buttons ^ btn($urandom_range(0, BTN_W - 1));
		endcase
		return sample_word(gen_buttons, pick_axis(), pick_axis(),
			$urandom_range(0, 1) ? pick_axis() : 16'sh0000,
			$urandom_range(0, 1) ? pick_axis() : 16'sh0000);
	endfunction

	task automatic push_word(input joy_word_t w);
		joy_pending_q.push_back(w);
		queued_cnt++;
	endtask

	// block is idle once every queued word is in and every result out
	task automatic wait_idle();
		while (accepted_cnt != queued_cnt || vel_expect_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup, access, then release; upper data bits are junk
	task automatic write_reg(input logic [2:0] idx, input logic [SCALE_W-1:0] val);
		logic [DATA_W-1:0] data;
		data = $urandom;
		data[SCALE_W-1:0] = val;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_LIN_MIN:  cfg_regs.lin_min = val;
			REG_LIN_MAX:  cfg_regs.lin_max = val;
			REG_LIN_STEP: cfg_regs.lin_step = val;
			REG_ANG_MIN:  cfg_regs.ang_min = val;
			REG_ANG_MAX:  cfg_regs.ang_max = val;
			REG_ANG_STEP: cfg_regs.ang_step = val;
			default: ;
		endcase
	endtask

	task automatic write_all(input int lmin, input int lmax, input int lstep,
			input int amin, input int amax, input int astep);
		write_reg(REG_LIN_MIN, lmin[SCALE_W-1:0]);
		write_reg(REG_LIN_MAX, lmax[SCALE_W-1:0]);
		write_reg(REG_LIN_STEP, lstep[SCALE_W-1:0]);
		write_reg(REG_ANG_MIN, amin[SCALE_W-1:0]);
		write_reg(REG_ANG_MAX, amax[SCALE_W-1:0]);
		write_reg(REG_ANG_STEP, astep[SCALE_W-1:0]);
	endtask

	// joystick word driver; predicts each word as it is accepted
	always @(posedge clk) begin
		if (joy_ch.valid && joy_ch.ready) begin
			advance_scaler(drive_word);
			accepted_cnt++;
		end
		if (!joy_ch.valid || joy_ch.ready) begin
			if (arst_n && joy_pending_q.size() > 0 &&
					$urandom_range(0, 99) >= src_idle_pct) begin
				drive_word = joy_pending_q.pop_front();
				joy_ch.valid <= 1'b1;
				joy_ch.op <= drive_word.op;
				joy_ch.buttons <= drive_word.buttons;
				joy_ch.stick_x <= drive_word.stick_x;
				joy_ch.stick_y <= drive_word.stick_y;
				joy_ch.pad_x <= drive_word.pad_x;
				joy_ch.pad_y <= drive_word.pad_y;
			end else begin
				joy_ch.valid <= 1'b0;
			end
		end
	end

	// velocity word monitor and ready control, with one long hold-off
	always @(posedge clk) begin
		if (arst_n && vel_ch.valid && vel_ch.ready) begin
			if (vel_expect_q.size() == 0) begin
				$error("velocity word with nothing expected: lin %0d ang %0d sending %0b",
					vel_ch.linear_velocity, vel_ch.angular_velocity, vel_ch.sending);
				mismatch_cnt++;
			end else begin
				want_word = vel_expect_q.pop_front();
				if (vel_ch.linear_velocity !== want_word.lin) begin
					$error("linear_velocity: expected %0d, got %0d",
						want_word.lin, vel_ch.linear_velocity);
					mismatch_cnt++;
				end
				if (vel_ch.angular_velocity !== want_word.ang) begin
					$error("angular_velocity: expected %0d, got %0d",
						want_word.ang, vel_ch.angular_velocity);
					mismatch_cnt++;
				end
				if (vel_ch.sending !== want_word.sending) begin
					$error("sending: expected %0b, got %0b", want_word.sending, vel_ch.sending);
					mismatch_cnt++;
				end
			end
		end
		if (hold_go && !hold_used) begin
			hold_left = HOLD_CYCLES;
			hold_used = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			vel_ch.ready <= 1'b0;
		end else begin
			vel_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((joy_ch.valid && joy_ch.ready) || (vel_ch.valid && vel_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// reset, directed words, then random phases at several register settings
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		joy_ch.valid = 1'b0;
		joy_ch.op = OP_SAMPLE;
		joy_ch.buttons = '0;
		joy_ch.stick_x = '0;
		joy_ch.stick_y = '0;
		joy_ch.pad_x = '0;
		joy_ch.pad_y = '0;
		vel_ch.ready = 1'b0;

		cfg_regs.lin_min = RST_LIN_MIN;
		cfg_regs.lin_max = RST_LIN_MAX;
		cfg_regs.lin_step = RST_LIN_STEP;
		cfg_regs.ang_min = RST_ANG_MIN;
		cfg_regs.ang_max = RST_ANG_MAX;
		cfg_regs.ang_step = RST_ANG_STEP;
		lin_scale_m = RST_LIN_MIN;
		ang_scale_m = RST_ANG_MIN;
		sending_m = 1'b1;
		held_lin_m = '0;
		held_ang_m = '0;
		last_buttons_m = '0;
		seen_sample_m = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// tick before any sample, then a first sample with every button down
		push_word(tick_word());
		push_word(sample_word('1, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000));
		push_word(tick_word());
		push_word(sample_word('0, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000));
		// each step button in turn, nonzero pads overriding the sticks
		push_word(sample_word(btn(BTN_ANG_DOWN), 16'sh7FFF, 16'sh8000,
			16'sh8000, 16'sh7FFF));
		push_word(sample_word(btn(BTN_LIN_DOWN), 16'sh8000, 16'sh7FFF,
			16'sh7FFF, 16'sh8000));
		push_word(sample_word(btn(BTN_ANG_UP), 16'sh4000, -16'sd1, 16'sh0000, 16'sd1));
		push_word(sample_word(btn(BTN_LIN_UP), -16'sd1, 16'sh8000, 16'sd1, 16'sh0000));
		push_word(tick_word());
		// buttons 6 and 7 do nothing
		push_word(sample_word(btn(6) | btn(7), 16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'sh0000));
		push_word(sample_word(btn(BTN_DISABLE), 16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'sh0000));
		push_word(tick_word());
		push_word(tick_word());
		push_word(sample_word(btn(BTN_ENABLE), 16'sd1, -16'sd1, 16'sh0000, 16'sh0000));
		push_word(tick_word());
		push_word(sample_word(btn(BTN_ALL_MIN), 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000));
		push_word(sample_word(btn(BTN_ALL_MAX), 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000));
		push_word(tick_word());
		push_word(sample_word('0, 16'sh1234, -16'sh1234, 16'sh0000, 16'sh0000));
		// all buttons rise together: only the highest priority acts
		push_word(sample_word('1, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'sh0000));
		push_word(tick_word());
		push_word(sample_word('0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
		push_word(tick_word());
		wait_idle();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			src_idle_pct = IDLE_PCT;
			sink_idle_pct = IDLE_PCT;
			case (ph)
				0: write_all($urandom_range(0, 4095), $urandom_range(4096, SCALE_TOP),
					$urandom_range(1, 2047), $urandom_range(0, 4095),
					$urandom_range(4096, SCALE_TOP), $urandom_range(1, 2047));
				1: write_all(SCALE_TOP, SCALE_TOP, SCALE_TOP, SCALE_TOP, SCALE_TOP, SCALE_TOP);
				2: write_all(0, 0, 0, 0, 0, 0);
				3: begin
					// minimum above maximum, plus writes to unused addresses
					write_all(30000, 1000, $urandom_range(0, SCALE_TOP),
						SCALE_TOP, 0, $urandom_range(0, SCALE_TOP));
					write_reg(REG_SPARE_LO, SCALE_W'($urandom));
					write_reg(REG_SPARE_HI, SCALE_W'($urandom));
					hold_go = 1'b1;
				end
				4: begin
					write_reg(REG_SPARE_HI, SCALE_W'($urandom));
					write_all($urandom_range(0, SCALE_TOP), $urandom_range(0, SCALE_TOP),
						$urandom_range(0, SCALE_TOP), $urandom_range(0, SCALE_TOP),
						$urandom_range(0, SCALE_TOP), $urandom_range(0, SCALE_TOP));
					src_idle_pct = 0;
					sink_idle_pct = 0;
				end
				default: write_all(RST_LIN_MIN, RST_LIN_MAX, RST_LIN_STEP,
					RST_ANG_MIN, RST_ANG_MAX, RST_ANG_STEP);
			endcase
			for (int n = 0; n < PHASE_WORDS; n++)
				push_word(random_word());
			wait_idle();
		end

		if (mismatch_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* joystick_velocity_command_scaler.f */
rtl/jvcs_pkg.sv
rtl/jvcs_if.sv
rtl/jvcs_ctrl.sv
rtl/joystick_velocity_command_scaler.sv
bench/testbench.sv
